[design/assert_macros.svh]
// Assertion macros shared by the RTL of the polygon triangulator.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in the same cycle implies the consequent
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`endif

[design/ecpt_pkg.sv]
// Package for the ear clipping triangulator: sizes, beat types, state codes.
// Used by ecpt_convex and ear_clip_polygon_triangulator_top.
`default_nettype none

package ecpt_pkg;

    // store and counter sizes
    localparam int MAX_VERTS = 64;
    localparam int VIDX_W    = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int TRY_W     = $clog2(MAX_VERTS * MAX_VERTS + 1);

    // field and arithmetic widths
    localparam int ID_W      = 16;
    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int NORM_W    = 42;
    localparam int THR_W     = 40;
    localparam int NLO_W     = NORM_W / 2;
    localparam int MUL_A_W   = NORM_W - NLO_W + 1;
    localparam int MUL_P_W   = MUL_A_W + CROSS_W;
    localparam int ACC_W     = 80;

    // convexity unit sequencing
    localparam int CVX_PH_W  = 4;
    localparam int CVX_LAST  = 10;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [NORM_W-1:0]  norm_t;

    typedef struct packed {
        logic [ID_W-1:0] vertex_id;
        coord_t          x_coord;
        coord_t          y_coord;
        coord_t          z_coord;
        logic            last_vertex;
    } vtx_in_t;

    typedef struct packed {
        logic            tri_valid;
        logic [ID_W-1:0] tri_first;
        logic [ID_W-1:0] tri_middle;
        logic [ID_W-1:0] tri_third;
        logic            last_result;
        logic            success;
    } tri_out_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } coord3_t;

    typedef struct packed {
        norm_t x;
        norm_t y;
        norm_t z;
    } norm3_t;

    typedef struct packed {
        logic [ID_W-1:0] id;
        coord3_t         pos;
    } vtx_t;

    typedef struct packed {
        logic [VIDX_W-1:0] prev_idx;
        logic [VIDX_W-1:0] next_idx;
        logic              convex;
    } link_t;

    typedef struct packed {
        logic done;
        logic gt;
        logic ge;
    } cvx_res_t;

    typedef enum logic [2:0] {
        SEL_ABC,
        SEL_ABP,
        SEL_BCP,
        SEL_CAP,
        SEL_PAC,
        SEL_ACQ
    } cvx_sel_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_NRM_FIRST_RD,
        ST_NRM_FIRST,
        ST_NRM_RD,
        ST_NRM_TERM,
        ST_NRM_MUL,
        ST_NRM_ACC,
        ST_INIT_RD_P,
        ST_INIT_RD_C,
        ST_INIT_RD_N,
        ST_INIT_CVX,
        ST_INIT_GO,
        ST_INIT_WAIT,
        ST_CLIP_CHECK,
        ST_CLIP_LINK,
        ST_EAR_RD_C,
        ST_EAR_RD_N,
        ST_EAR_GOT_N,
        ST_SCAN_CHECK,
        ST_SCAN_DATA,
        ST_SCAN_GO0,
        ST_SCAN_W0,
        ST_SCAN_GO1,
        ST_SCAN_W1,
        ST_SCAN_GO2,
        ST_SCAN_W2,
        ST_EMIT,
        ST_UPD_RD_N,
        ST_UPD_GOT_N,
        ST_UPD_V1,
        ST_UPD_V2,
        ST_UPD_GO0
    } state_t;

    // second half of the update sequence, kept in its own small enum
    typedef enum logic [1:0] {
        UP_W0,
        UP_GO1,
        UP_W1,
        UP_WR
    } upd_t;

    // sign-extend a coordinate to difference width
    function automatic diff_t widen(coord_t v);
        return DIFF_W'(v);
    endfunction

endpackage

`default_nettype wire

[design/ecpt_convex.sv]
// Convexity unit: dot(N, (b-a) x (c-a)) compared against +/- threshold.
// Multi-cycle, one 22x35 multiplier shared over six partial products; uses ecpt_pkg.
`default_nettype none

module ecpt_convex
    import ecpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  coord3_t          a,
    input  coord3_t          b,
    input  coord3_t          c,
    input  norm3_t           normal,
    input  logic [THR_W-1:0] threshold,
    output cvx_res_t         res
);

    logic                     run_reg;
    logic [CVX_PH_W-1:0]      phase_reg;
    logic                     done_reg;
    logic                     gt_reg;
    logic                     ge_reg;

    diff_t                    ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [MUL_P_W-1:0] prod_reg;
    logic                     half_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic [2:0]               k;
    norm_t                    n_sel;
    logic signed [CROSS_W-1:0] c_sel;
    logic signed [MUL_A_W-1:0] m_a;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  thr_pos;
    logic signed [ACC_W-1:0]  thr_neg;
    logic                     mul_phase;
    logic                     acc_phase;

    // partial product index and operand selection
    assign k         = 3'(phase_reg - CVX_PH_W'(3));
    assign mul_phase = run_reg && (phase_reg >= CVX_PH_W'(3)) && (phase_reg <= CVX_PH_W'(8));
    assign acc_phase = run_reg && (phase_reg >= CVX_PH_W'(4)) && (phase_reg <= CVX_PH_W'(9));

    always_comb
    begin
        unique case (k[2:1])
            2'd0:
            begin
                n_sel = normal.x;
                c_sel = cx_reg;
            end
            2'd1:
            begin
                n_sel = normal.y;
                c_sel = cy_reg;
            end
            default:
            begin
                n_sel = normal.z;
                c_sel = cz_reg;
            end
        endcase
    end

    // low half unsigned, high half signed and shifted on accumulate
    assign m_a = k[0] ? {n_sel[NORM_W-1], n_sel[NORM_W-1:NLO_W]}
                      : {{(MUL_A_W-NLO_W){1'b0}}, n_sel[NLO_W-1:0]};

    assign addend = half_reg
        ? {{(ACC_W-MUL_P_W-NLO_W){prod_reg[MUL_P_W-1]}}, prod_reg, {NLO_W{1'b0}}}
        : {{(ACC_W-MUL_P_W){prod_reg[MUL_P_W-1]}}, prod_reg};

    assign thr_pos = {{(ACC_W-THR_W){1'b0}}, threshold};
    assign thr_neg = -thr_pos;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (phase_reg == CVX_PH_W'(CVX_LAST));
            if (start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= CVX_PH_W'(1);
            end
            else if (run_reg)
            begin
                if (phase_reg == CVX_PH_W'(CVX_LAST))
                    run_reg <= 1'b0;
                phase_reg <= phase_reg + CVX_PH_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ux_reg <= widen(b.x) - widen(a.x);
            uy_reg <= widen(b.y) - widen(a.y);
            uz_reg <= widen(b.z) - widen(a.z);
            vx_reg <= widen(c.x) - widen(a.x);
            vy_reg <= widen(c.y) - widen(a.y);
            vz_reg <= widen(c.z) - widen(a.z);
        end
        if (run_reg && phase_reg == CVX_PH_W'(1))
        begin
            p0_reg <= uy_reg * vz_reg;
            p1_reg <= uz_reg * vy_reg;
            p2_reg <= uz_reg * vx_reg;
            p3_reg <= ux_reg * vz_reg;
            p4_reg <= ux_reg * vy_reg;
            p5_reg <= uy_reg * vx_reg;
        end
        if (run_reg && phase_reg == CVX_PH_W'(2))
        begin
            cx_reg  <= CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
            cy_reg  <= CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
            cz_reg  <= CROSS_W'(p4_reg) - CROSS_W'(p5_reg);
            acc_reg <= '0;
        end
        if (mul_phase)
        begin
            prod_reg <= m_a * c_sel;
            half_reg <= k[0];
        end
        if (acc_phase)
            acc_reg <= acc_reg + addend;
        if (run_reg && phase_reg == CVX_PH_W'(CVX_LAST))
        begin
            gt_reg <= acc_reg > thr_pos;
            ge_reg <= acc_reg >= thr_neg;
        end
    end

    assign res = '{done: done_reg, gt: gt_reg, ge: ge_reg};

endmodule

`default_nettype wire

[design/ear_clip_polygon_triangulator_top.sv]
// Top level of the ear clipping polygon triangulator.
// Depends on ecpt_pkg, ecpt_convex and assert_macros.svh.
`default_nettype none
//
// Usage:
//  - Vertices come in as beats on 'vertex', taken at each edge with start high
//    and busy low: one beat a cycle while loading. Up to 64 are stored; more
//    are dropped. The beat with last_vertex set starts the work and raises busy.
//  - Work: Newell normal; then ring setup with one convexity test a vertex;
//    then clipping steps (at most n*n), each a pass through the clipping
//    states plus its convexity tests. All tests share the one convexity unit,
//    and the vertex and link memories each have a single read port.
//  - Each clipped ear gives one triangle beat on 'result' with strobe high for
//    one cycle; a status beat with last_result set ends the polygon, and busy
//    drops in that same cycle. The receiver cannot stall.
//  - Threshold: to be written via cfg_we/cfg_wdata while idle; not enforced.
//  - Reset zeroes all counters and the threshold; memories need no clearing.

`include "assert_macros.svh"

module ear_clip_polygon_triangulator_top
    import ecpt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  vtx_in_t          vertex,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    output logic             strobe,
    output tri_out_t         result
);

    state_t state_reg, state_next;
    upd_t   upd_reg, upd_next;
    logic   in_upd_reg, in_upd_next;

    logic [THR_W-1:0]  thr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              wrap_reg;
    norm3_t            norm_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [VIDX_W-1:0] cur_reg;
    logic [TRY_W-1:0]  tries_reg;
    logic [TRY_W-1:0]  max_tries_reg;
    logic              strobe_reg;
    logic              ear_reg;
    tri_out_t          result_reg;

    coord3_t first_reg, prev_reg;
    diff_t   dx_reg, dy_reg, dz_reg, sx_reg, sy_reg, sz_reg;
    logic signed [PROD_W-1:0] tpx_reg, tpy_reg, tpz_reg;

    logic [VIDX_W-1:0] pv_reg, nx_reg, t_reg, t_next_reg, ppv_reg, nnx_reg;
    logic [ID_W-1:0]   id_p_reg, id_c_reg, id_n_reg;
    coord3_t           ta_reg, tb_reg, tc_reg, p_reg, q_reg;
    logic              r0_reg, r1_reg, cpv_reg, cnx_reg;

    // memories
    vtx_t  vmem [MAX_VERTS];
    link_t lmem [MAX_VERTS];
    vtx_t  v_rd_reg;
    link_t l_rd_reg;

    logic [VIDX_W-1:0] v_raddr, l_raddr, l_waddr;
    logic              v_we, l_we;
    link_t             l_wdata;

    logic       cvx_start;
    cvx_sel_t   cvx_sel;
    coord3_t    cvx_a, cvx_b, cvx_c;
    cvx_res_t   cvx_res;

    logic             accept;
    logic             store_ok;
    logic [CNT_W-1:0] n_last;
    logic [CNT_W-1:0] init_prv, init_nxt;
    logic             clip_go;
    logic             id_match;
    logic             in_tri;
    coord3_t          term_cur;

    assign busy     = (state_reg != ST_LOAD) || in_upd_reg;
    assign accept   = start && !busy;
    assign store_ok = count_reg < CNT_W'(MAX_VERTS);
    assign v_we     = accept && store_ok;
    assign n_last   = count_reg - CNT_W'(1);
    assign init_prv = (idx_reg == '0) ? n_last : idx_reg - CNT_W'(1);
    assign init_nxt = (idx_reg == n_last) ? '0 : idx_reg + CNT_W'(1);
    assign clip_go  = (rem_reg > CNT_W'(2)) && (tries_reg < max_tries_reg);
    assign id_match = (v_rd_reg.id == id_p_reg) || (v_rd_reg.id == id_c_reg) ||
                      (v_rd_reg.id == id_n_reg);
    assign in_tri   = r0_reg && r1_reg && cvx_res.ge;
    assign term_cur = wrap_reg ? first_reg : v_rd_reg.pos;

    // convexity unit and its operand select
    always_comb
    begin
        unique case (cvx_sel)
            SEL_ABC: begin cvx_a = ta_reg; cvx_b = tb_reg; cvx_c = tc_reg; end
            SEL_ABP: begin cvx_a = ta_reg; cvx_b = tb_reg; cvx_c = p_reg;  end
            SEL_BCP: begin cvx_a = tb_reg; cvx_b = tc_reg; cvx_c = p_reg;  end
            SEL_CAP: begin cvx_a = tc_reg; cvx_b = ta_reg; cvx_c = p_reg;  end
            SEL_PAC: begin cvx_a = p_reg;  cvx_b = ta_reg; cvx_c = tc_reg; end
            SEL_ACQ: begin cvx_a = ta_reg; cvx_b = tc_reg; cvx_c = q_reg;  end
            default: begin cvx_a = ta_reg; cvx_b = tb_reg; cvx_c = tc_reg; end
        endcase
    end

    ecpt_convex u_convex (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cvx_start),
        .a         (cvx_a),
        .b         (cvx_b),
        .c         (cvx_c),
        .normal    (norm_reg),
        .threshold (thr_reg),
        .res       (cvx_res)
    );

    // next state
    always_comb
    begin
        state_next  = state_reg;
        upd_next    = upd_reg;
        in_upd_next = in_upd_reg;
        if (in_upd_reg)
        begin
            unique case (upd_reg)
                UP_W0:  if (cvx_res.done) upd_next = UP_GO1;
                UP_GO1: upd_next = UP_W1;
                UP_W1:  if (cvx_res.done) upd_next = UP_WR;
                UP_WR:
                begin
                    in_upd_next = 1'b0;
                    state_next  = ST_CLIP_CHECK;
                end
                default: upd_next = UP_W0;
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_LOAD:         if (accept && vertex.last_vertex) state_next = ST_NRM_FIRST_RD;
                ST_NRM_FIRST_RD: state_next = ST_NRM_FIRST;
                ST_NRM_FIRST:    state_next = ST_NRM_RD;
                ST_NRM_RD:       state_next = ST_NRM_TERM;
                ST_NRM_TERM:     state_next = ST_NRM_MUL;
                ST_NRM_MUL:      state_next = ST_NRM_ACC;
                ST_NRM_ACC:      state_next = wrap_reg ? ST_INIT_RD_P : ST_NRM_RD;
                ST_INIT_RD_P:    state_next = ST_INIT_RD_C;
                ST_INIT_RD_C:    state_next = ST_INIT_RD_N;
                ST_INIT_RD_N:    state_next = ST_INIT_CVX;
                ST_INIT_CVX:     state_next = ST_INIT_GO;
                ST_INIT_GO:      state_next = ST_INIT_WAIT;
                ST_INIT_WAIT:
                    if (cvx_res.done)
                        state_next = (idx_reg == n_last) ? ST_CLIP_CHECK : ST_INIT_RD_P;
                ST_CLIP_CHECK:   state_next = clip_go ? ST_CLIP_LINK : ST_EMIT;
                ST_CLIP_LINK:    state_next = l_rd_reg.convex ? ST_EAR_RD_C : ST_CLIP_CHECK;
                ST_EAR_RD_C:     state_next = ST_EAR_RD_N;
                ST_EAR_RD_N:     state_next = ST_EAR_GOT_N;
                ST_EAR_GOT_N:    state_next = ST_SCAN_CHECK;
                ST_SCAN_CHECK:   state_next = (t_reg == cur_reg) ? ST_EMIT : ST_SCAN_DATA;
                ST_SCAN_DATA:    state_next = id_match ? ST_SCAN_CHECK : ST_SCAN_GO0;
                ST_SCAN_GO0:     state_next = ST_SCAN_W0;
                ST_SCAN_W0:      if (cvx_res.done) state_next = ST_SCAN_GO1;
                ST_SCAN_GO1:     state_next = ST_SCAN_W1;
                ST_SCAN_W1:      if (cvx_res.done) state_next = ST_SCAN_GO2;
                ST_SCAN_GO2:     state_next = ST_SCAN_W2;
                ST_SCAN_W2:
                    if (cvx_res.done)
                        state_next = in_tri ? ST_CLIP_CHECK : ST_SCAN_CHECK;
                // EMIT serves both a triangle (after a scan) and the status beat
                ST_EMIT:         state_next = ear_reg ? ST_UPD_RD_N : ST_LOAD;
                ST_UPD_RD_N:     state_next = ST_UPD_GOT_N;
                ST_UPD_GOT_N:    state_next = ST_UPD_V1;
                ST_UPD_V1:       state_next = ST_UPD_V2;
                ST_UPD_V2:       state_next = ST_UPD_GO0;
                ST_UPD_GO0:
                begin
                    in_upd_next = 1'b1;
                    upd_next    = UP_W0;
                end
                default:         state_next = ST_LOAD;
            endcase
        end
    end

    // control outputs: memory ports and convexity unit start
    always_comb
    begin
        v_raddr   = '0;
        l_raddr   = '0;
        l_we      = 1'b0;
        l_waddr   = '0;
        l_wdata   = '0;
        cvx_start = 1'b0;
        cvx_sel   = SEL_ABC;
        if (in_upd_reg)
        begin
            unique case (upd_reg)
                UP_GO1:
                begin
                    cvx_start = 1'b1;
                    cvx_sel   = SEL_ACQ;
                end
                UP_W1:
                begin
                    l_we    = cvx_res.done;
                    l_waddr = pv_reg;
                    l_wdata = '{prev_idx: ppv_reg, next_idx: nx_reg, convex: cpv_reg};
                end
                UP_WR:
                begin
                    l_we    = 1'b1;
                    l_waddr = nx_reg;
                    l_wdata = '{prev_idx: pv_reg, next_idx: nnx_reg, convex: cnx_reg};
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_NRM_RD:     v_raddr = idx_reg[VIDX_W-1:0];
                ST_INIT_RD_P:  v_raddr = init_prv[VIDX_W-1:0];
                ST_INIT_RD_C:  v_raddr = idx_reg[VIDX_W-1:0];
                ST_INIT_RD_N:  v_raddr = init_nxt[VIDX_W-1:0];
                ST_INIT_GO:    cvx_start = 1'b1;
                ST_INIT_WAIT:
                begin
                    l_we    = cvx_res.done;
                    l_waddr = idx_reg[VIDX_W-1:0];
                    l_wdata = '{prev_idx: init_prv[VIDX_W-1:0],
                                next_idx: init_nxt[VIDX_W-1:0],
                                convex:   cvx_res.gt};
                end
                ST_CLIP_CHECK: l_raddr = cur_reg;
                ST_CLIP_LINK:  v_raddr = l_rd_reg.prev_idx;
                ST_EAR_RD_C:   v_raddr = cur_reg;
                ST_EAR_RD_N:   v_raddr = nx_reg;
                ST_SCAN_CHECK:
                begin
                    v_raddr = t_reg;
                    l_raddr = t_reg;
                end
                ST_SCAN_GO0:
                begin
                    cvx_start = 1'b1;
                    cvx_sel   = SEL_ABP;
                end
                ST_SCAN_GO1:
                begin
                    cvx_start = 1'b1;
                    cvx_sel   = SEL_BCP;
                end
                ST_SCAN_GO2:
                begin
                    cvx_start = 1'b1;
                    cvx_sel   = SEL_CAP;
                end
                ST_EMIT:       l_raddr = pv_reg;
                ST_UPD_RD_N:   l_raddr = nx_reg;
                ST_UPD_GOT_N:  v_raddr = ppv_reg;
                ST_UPD_V1:     v_raddr = nnx_reg;
                ST_UPD_GO0:
                begin
                    cvx_start = 1'b1;
                    cvx_sel   = SEL_PAC;
                end
                default: ;
            endcase
        end
    end

    // vertex and link memories, registered reads
    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[count_reg[VIDX_W-1:0]] <= '{id: vertex.vertex_id,
                                             pos: '{x: vertex.x_coord,
                                                    y: vertex.y_coord,
                                                    z: vertex.z_coord}};
        v_rd_reg <= vmem[v_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            lmem[l_waddr] <= l_wdata;
        l_rd_reg <= lmem[l_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            upd_reg       <= UP_W0;
            in_upd_reg    <= 1'b0;
            thr_reg       <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            wrap_reg      <= 1'b0;
            norm_reg      <= '0;
            rem_reg       <= '0;
            cur_reg       <= '0;
            tries_reg     <= '0;
            max_tries_reg <= '0;
            strobe_reg    <= 1'b0;
            ear_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            upd_reg    <= upd_next;
            in_upd_reg <= in_upd_next;
            strobe_reg <= 1'b0;
            if (cfg_we)
                thr_reg <= cfg_wdata;
            if (in_upd_reg)
            begin
                if (upd_reg == UP_WR)
                    cur_reg <= nx_reg;
            end
            else
            begin
                unique case (state_reg)
                    ST_LOAD:
                        if (v_we)
                            count_reg <= count_reg + CNT_W'(1);
                    ST_NRM_FIRST_RD: norm_reg <= '0;
                    ST_NRM_FIRST:    idx_reg  <= CNT_W'(1);
                    ST_NRM_RD:       wrap_reg <= (idx_reg == count_reg);
                    ST_NRM_ACC:
                    begin
                        norm_reg.x <= norm_reg.x + NORM_W'(tpx_reg);
                        norm_reg.y <= norm_reg.y + NORM_W'(tpy_reg);
                        norm_reg.z <= norm_reg.z + NORM_W'(tpz_reg);
                        idx_reg    <= wrap_reg ? '0 : idx_reg + CNT_W'(1);
                    end
                    ST_INIT_WAIT:
                        if (cvx_res.done)
                        begin
                            idx_reg <= idx_reg + CNT_W'(1);
                            if (idx_reg == n_last)
                            begin
                                rem_reg       <= count_reg;
                                cur_reg       <= '0;
                                tries_reg     <= '0;
                                max_tries_reg <= TRY_W'(count_reg) * TRY_W'(count_reg);
                            end
                        end
                    ST_CLIP_CHECK:
                    begin
                        ear_reg <= 1'b0;
                        if (clip_go)
                            tries_reg <= tries_reg + TRY_W'(1);
                    end
                    ST_CLIP_LINK:
                        if (!l_rd_reg.convex)
                            cur_reg <= l_rd_reg.next_idx;
                    // scan ran around the ring: an ear is found
                    ST_SCAN_CHECK:
                        ear_reg <= (t_reg == cur_reg);
                    ST_SCAN_W2:
                        if (cvx_res.done && in_tri)
                            cur_reg <= nx_reg;
                    ST_EMIT:
                    begin
                        strobe_reg <= 1'b1;
                        if (ear_reg)
                            rem_reg <= rem_reg - CNT_W'(1);
                        else
                        begin
                            // status beat: polygon done, back to loading
                            count_reg <= '0;
                            rem_reg   <= '0;
                            cur_reg   <= '0;
                            tries_reg <= '0;
                            norm_reg  <= '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_upd_reg)
        begin
            if (upd_reg == UP_W0 && cvx_res.done)
                cpv_reg <= cvx_res.gt;
            if (upd_reg == UP_W1 && cvx_res.done)
                cnx_reg <= cvx_res.gt;
        end
        else
        begin
            unique case (state_reg)
                ST_NRM_FIRST:
                begin
                    first_reg <= v_rd_reg.pos;
                    prev_reg  <= v_rd_reg.pos;
                end
                ST_NRM_TERM:
                begin
                    dx_reg   <= widen(prev_reg.x) - widen(term_cur.x);
                    dy_reg   <= widen(prev_reg.y) - widen(term_cur.y);
                    dz_reg   <= widen(prev_reg.z) - widen(term_cur.z);
                    sx_reg   <= widen(prev_reg.x) + widen(term_cur.x);
                    sy_reg   <= widen(prev_reg.y) + widen(term_cur.y);
                    sz_reg   <= widen(prev_reg.z) + widen(term_cur.z);
                    prev_reg <= term_cur;
                end
                ST_NRM_MUL:
                begin
                    tpx_reg <= dy_reg * sz_reg;
                    tpy_reg <= dz_reg * sx_reg;
                    tpz_reg <= dx_reg * sy_reg;
                end
                ST_INIT_RD_C:  ta_reg <= v_rd_reg.pos;
                ST_INIT_RD_N:  tb_reg <= v_rd_reg.pos;
                ST_INIT_CVX:   tc_reg <= v_rd_reg.pos;
                ST_CLIP_LINK:
                begin
                    pv_reg <= l_rd_reg.prev_idx;
                    nx_reg <= l_rd_reg.next_idx;
                end
                ST_EAR_RD_C:
                begin
                    ta_reg   <= v_rd_reg.pos;
                    id_p_reg <= v_rd_reg.id;
                end
                ST_EAR_RD_N:
                begin
                    tb_reg   <= v_rd_reg.pos;
                    id_c_reg <= v_rd_reg.id;
                end
                ST_EAR_GOT_N:
                begin
                    tc_reg   <= v_rd_reg.pos;
                    id_n_reg <= v_rd_reg.id;
                    t_reg    <= nx_reg;
                end
                ST_SCAN_DATA:
                begin
                    p_reg      <= v_rd_reg.pos;
                    t_next_reg <= l_rd_reg.next_idx;
                    if (id_match)
                        t_reg <= l_rd_reg.next_idx;
                end
                ST_SCAN_W0:    if (cvx_res.done) r0_reg <= cvx_res.ge;
                ST_SCAN_W1:    if (cvx_res.done) r1_reg <= cvx_res.ge;
                ST_SCAN_W2:
                    if (cvx_res.done && !in_tri)
                        t_reg <= t_next_reg;
                ST_EMIT:
                    if (ear_reg)
                        result_reg <= '{tri_valid: 1'b1, tri_first: id_p_reg,
                                        tri_middle: id_c_reg, tri_third: id_n_reg,
                                        last_result: 1'b0, success: 1'b0};
                    else
                        result_reg <= '{tri_valid: 1'b0, tri_first: '0,
                                        tri_middle: '0, tri_third: '0,
                                        last_result: 1'b1,
                                        success: (rem_reg == CNT_W'(2))};
                ST_UPD_RD_N:   ppv_reg <= l_rd_reg.prev_idx;
                ST_UPD_GOT_N:  nnx_reg <= l_rd_reg.next_idx;
                ST_UPD_V1:     p_reg   <= v_rd_reg.pos;
                ST_UPD_V2:     q_reg   <= v_rd_reg.pos;
                default: ;
            endcase
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // checks
    `ASSERT_IMPLIES(a_tri_while_busy, clk, rst_n, strobe && result.tri_valid, busy)
    `ASSERT_IMPLIES(a_status_idle, clk, rst_n, strobe && result.last_result, !busy && count_reg == '0)
    `ASSERT_ALWAYS(a_rem_bound, clk, rst_n, rem_reg <= count_reg)
    `ASSERT_ALWAYS(a_tries_bound, clk, rst_n, tries_reg <= max_tries_reg)

endmodule

`default_nettype wire
